@@ rtl/aose_pkg.sv @@
// Shared types, constants and helpers of the annealing offset swap engine.
package aose_pkg;

  localparam int unsigned CoordBits  = 6;
  localparam int unsigned CellBits   = 2 * CoordBits;
  localparam int unsigned CellCount  = 1 << CellBits;
  localparam int unsigned PixBits    = 8;
  localparam int unsigned OffBits    = 4;
  localparam int unsigned MaxOffset  = 6;
  localparam int unsigned EnergyBits = 20;
  localparam int unsigned CountBits  = 24;
  localparam int unsigned DeltaBits  = 10;
  localparam int unsigned ThrBits    = 10;
  localparam int unsigned StatusBits = 3;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_PROPOSE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_LOADED         = 3'd0,
    ST_NOT_APPLICABLE = 3'd1,
    ST_ACCEPTED       = 3'd2,
    ST_DECLINED       = 3'd3,
    ST_READOUT        = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    OP_IDLE   = 5'd0,
    OP_CLEAR  = 5'd1,
    OP_LOAD   = 5'd2,
    OP_R_SRC  = 5'd3,
    OP_R_OFF  = 5'd4,
    OP_R_FIN  = 5'd5,
    OP_P_SRC1 = 5'd6,
    OP_P_OFF1 = 5'd7,
    OP_P_CHK1 = 5'd8,
    OP_P_OFF2 = 5'd9,
    OP_P_CHK2 = 5'd10,
    OP_P_RD3  = 5'd11,
    OP_P_RD4  = 5'd12,
    OP_P_EVAL = 5'd13,
    OP_P_DEC  = 5'd14,
    OP_P_WB2  = 5'd15,
    OP_DONE   = 5'd16
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   take;
    logic   push;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic ok1;
    logic ok2;
    logic accept;
    logic slot_free;
  } stat_t;

  // Toroidal add of a signed offset to a coordinate.
  function automatic logic [CoordBits-1:0] wrap_coord(input logic [CoordBits-1:0] s,
                                                       input logic [OffBits-1:0]   o);
    wrap_coord = s + {{(CoordBits-OffBits){o[OffBits-1]}}, o};
  endfunction

  function automatic logic [PixBits-1:0] abs_diff(input logic [PixBits-1:0] a,
                                                   input logic [PixBits-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

@@ rtl/aose_in_if.sv @@
// Request and result channel interfaces of the annealing offset swap engine.
interface aose_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           mode;
  logic [aose_pkg::CoordBits-1:0]       pos_x;
  logic [aose_pkg::CoordBits-1:0]       pos_y;
  logic signed [aose_pkg::OffBits-1:0]  step_x;
  logic signed [aose_pkg::OffBits-1:0]  step_y;
  logic [aose_pkg::PixBits-1:0]         current_value;
  logic [aose_pkg::PixBits-1:0]         target_value;
  logic [aose_pkg::ThrBits-1:0]         accept_threshold;

  modport source (output valid, mode, pos_x, pos_y, step_x, step_y, current_value,
                  target_value, accept_threshold, input ready);
  modport sink (input valid, mode, pos_x, pos_y, step_x, step_y, current_value,
                target_value, accept_threshold, output ready);
endinterface

interface aose_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [aose_pkg::StatusBits-1:0]       status;
  logic signed [aose_pkg::DeltaBits-1:0] energy_delta;
  logic [aose_pkg::EnergyBits-1:0]       total_energy;
  logic [aose_pkg::CountBits-1:0]        accepted_count;
  logic signed [aose_pkg::OffBits-1:0]   read_offset_x;
  logic signed [aose_pkg::OffBits-1:0]   read_offset_y;
  logic [aose_pkg::CoordBits-1:0]        read_source_x;
  logic [aose_pkg::CoordBits-1:0]        read_source_y;

  modport source (output valid, status, energy_delta, total_energy, accepted_count,
                  read_offset_x, read_offset_y, read_source_x, read_source_y, input ready);
  modport sink (input valid, status, energy_delta, total_energy, accepted_count,
                read_offset_x, read_offset_y, read_source_x, read_source_y, output ready);
endinterface

@@ rtl/aose_ctrl.sv @@
// Sequencing state machine of the annealing offset swap engine.
module aose_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_mode_i,
  output logic                in_ready_o,
  input  aose_pkg::stat_t     stat_i,
  output aose_pkg::cmd_t      cmd_o
);

  typedef enum logic [16:0] {
    S_CLEAR  = 17'b00000000000000001,
    S_IDLE   = 17'b00000000000000010,
    S_LOAD   = 17'b00000000000000100,
    S_R_SRC  = 17'b00000000000001000,
    S_R_OFF  = 17'b00000000000010000,
    S_R_FIN  = 17'b00000000000100000,
    S_P_SRC1 = 17'b00000000001000000,
    S_P_OFF1 = 17'b00000000010000000,
    S_P_CHK1 = 17'b00000000100000000,
    S_P_OFF2 = 17'b00000001000000000,
    S_P_CHK2 = 17'b00000010000000000,
    S_P_RD3  = 17'b00000100000000000,
    S_P_RD4  = 17'b00001000000000000,
    S_P_EVAL = 17'b00010000000000000,
    S_P_DEC  = 17'b00100000000000000,
    S_P_WB2  = 17'b01000000000000000,
    S_DONE   = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o = (state_q == S_IDLE);
  assign take       = in_ready_o && in_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (stat_i.clear_last) state_d = S_IDLE;
      S_IDLE: begin
        if (take) begin
          case (aose_pkg::mode_e'(in_mode_i))
            aose_pkg::MODE_LOAD:    state_d = S_LOAD;
            aose_pkg::MODE_PROPOSE: state_d = S_P_SRC1;
            aose_pkg::MODE_READ:    state_d = S_R_SRC;
            default:                state_d = S_IDLE;
          endcase
        end
      end
      S_LOAD:   state_d = S_DONE;
      S_R_SRC:  state_d = S_R_OFF;
      S_R_OFF:  state_d = S_R_FIN;
      S_R_FIN:  state_d = S_DONE;
      S_P_SRC1: state_d = S_P_OFF1;
      S_P_OFF1: state_d = S_P_CHK1;
      S_P_CHK1: state_d = stat_i.ok1 ? S_P_OFF2 : S_DONE;
      S_P_OFF2: state_d = S_P_CHK2;
      S_P_CHK2: state_d = stat_i.ok2 ? S_P_RD3 : S_DONE;
      S_P_RD3:  state_d = S_P_RD4;
      S_P_RD4:  state_d = S_P_EVAL;
      S_P_EVAL: state_d = S_P_DEC;
      S_P_DEC:  state_d = stat_i.accept ? S_P_WB2 : S_DONE;
      S_P_WB2:  state_d = S_DONE;
      S_DONE:   if (stat_i.slot_free) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o.take = take;
    cmd_o.push = (state_q == S_DONE) && stat_i.slot_free;
    case (state_q)
      S_CLEAR:  cmd_o.op = aose_pkg::OP_CLEAR;
      S_IDLE:   cmd_o.op = aose_pkg::OP_IDLE;
      S_LOAD:   cmd_o.op = aose_pkg::OP_LOAD;
      S_R_SRC:  cmd_o.op = aose_pkg::OP_R_SRC;
      S_R_OFF:  cmd_o.op = aose_pkg::OP_R_OFF;
      S_R_FIN:  cmd_o.op = aose_pkg::OP_R_FIN;
      S_P_SRC1: cmd_o.op = aose_pkg::OP_P_SRC1;
      S_P_OFF1: cmd_o.op = aose_pkg::OP_P_OFF1;
      S_P_CHK1: cmd_o.op = aose_pkg::OP_P_CHK1;
      S_P_OFF2: cmd_o.op = aose_pkg::OP_P_OFF2;
      S_P_CHK2: cmd_o.op = aose_pkg::OP_P_CHK2;
      S_P_RD3:  cmd_o.op = aose_pkg::OP_P_RD3;
      S_P_RD4:  cmd_o.op = aose_pkg::OP_P_RD4;
      S_P_EVAL: cmd_o.op = aose_pkg::OP_P_EVAL;
      S_P_DEC:  cmd_o.op = aose_pkg::OP_P_DEC;
      S_P_WB2:  cmd_o.op = aose_pkg::OP_P_WB2;
      S_DONE:   cmd_o.op = aose_pkg::OP_DONE;
      default:  cmd_o.op = aose_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (in_mode_i == aose_pkg::MODE_LOAD) |=> state_q == S_LOAD)
    else $error("load request did not enter the load step");

  a_wb_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_P_WB2 |-> $past(state_q == S_P_DEC && stat_i.accept))
    else $error("second write-back without an accepted swap");

  a_bound_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_P_OFF2 |-> $past(stat_i.ok1))
    else $error("partner lookup after a failed offset bound");

endmodule

@@ rtl/aose_datapath.sv @@
// Map memories, image memories, energy and result registers of the swap engine.
module aose_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  aose_in_if.sink          in_i,
  aose_out_if.source       out_o,
  input  aose_pkg::cmd_t   cmd_i,
  output aose_pkg::stat_t  stat_o
);

  localparam int unsigned CB = aose_pkg::CoordBits;
  localparam int unsigned LB = aose_pkg::CellBits;
  localparam int unsigned PB = aose_pkg::PixBits;
  localparam int unsigned OB = aose_pkg::OffBits;
  localparam int unsigned EB = aose_pkg::EnergyBits;
  localparam int unsigned NB = aose_pkg::CountBits;
  localparam int unsigned DB = aose_pkg::DeltaBits;
  localparam logic signed [OB:0] OffHi = (OB+1)'(aose_pkg::MaxOffset);
  localparam logic signed [OB:0] OffLo = -OffHi;
  localparam logic [EB-1:0] EnergyMax = '1;
  localparam logic [NB-1:0] CountMax  = '1;

  // memories
  logic [PB-1:0]     cur_mem [aose_pkg::CellCount];
  logic [PB-1:0]     tgt_mem [aose_pkg::CellCount];
  logic [2*OB-1:0]   off_mem [aose_pkg::CellCount];
  logic [LB-1:0]     src_mem [aose_pkg::CellCount];

  logic [LB-1:0]   cur_ra, tgt_ra, off_ra, src_ra, img_wa, off_wa, src_wa;
  logic            img_we, off_we, src_we;
  logic [2*OB-1:0] off_wd;
  logic [LB-1:0]   src_wd;
  logic [PB-1:0]   cur_rd, tgt_rd;
  logic [2*OB-1:0] off_rd;
  logic [LB-1:0]   src_rd;

  // request registers
  logic [LB-1:0]        p_q;
  logic signed [OB-1:0] stx_q, sty_q;
  logic [PB-1:0]        cv_q, tv_q;
  logic [aose_pkg::ThrBits-1:0] thr_q;

  // swap working registers
  logic [LB-1:0]   s1_q, s2_q, q_q, clr_q;
  logic [2*OB-1:0] o1_q, n1_q, n2_q;
  logic [PB-1:0]   cur1_q, cur2_q, tn1_q, to1_q, to2_q, tn2_q;
  logic signed [DB-1:0] delta_q;

  // result staging and output
  logic [aose_pkg::StatusBits-1:0] res_status_q;
  logic signed [DB-1:0] res_delta_q;
  logic [2*OB-1:0]      res_off_q;
  logic [LB-1:0]        res_src_q;
  logic [EB-1:0]        energy_q;
  logic [NB-1:0]        count_q;
  logic                 ov_q;

  logic signed [OB:0] n1x, n1y, n2x, n2y;
  logic               ok1, ok2, accept;
  logic [LB-1:0]      q_cell;
  logic [PB:0]        old_e, new_e;
  logic signed [DB:0] delta_w;
  logic signed [DB:0] add_v;
  logic signed [EB+1:0] esum;
  logic               energy_we;

  assign n1x = $signed({off_rd[OB-1], off_rd[OB-1:0]}) + $signed({stx_q[OB-1], stx_q});
  assign n1y = $signed({off_rd[2*OB-1], off_rd[2*OB-1:OB]}) + $signed({sty_q[OB-1], sty_q});
  assign n2x = $signed({off_rd[OB-1], off_rd[OB-1:0]}) - $signed({stx_q[OB-1], stx_q});
  assign n2y = $signed({off_rd[2*OB-1], off_rd[2*OB-1:OB]}) - $signed({sty_q[OB-1], sty_q});
  assign ok1 = (n1x >= OffLo) && (n1x <= OffHi) && (n1y >= OffLo) && (n1y <= OffHi);
  assign ok2 = (n2x >= OffLo) && (n2x <= OffHi) && (n2y >= OffLo) && (n2y <= OffHi);
  assign q_cell = {aose_pkg::wrap_coord(s1_q[LB-1:CB], n1y[OB-1:0]),
                   aose_pkg::wrap_coord(s1_q[CB-1:0], n1x[OB-1:0])};

  assign old_e = {1'b0, aose_pkg::abs_diff(cur1_q, to1_q)}
               + {1'b0, aose_pkg::abs_diff(cur2_q, to2_q)};
  assign new_e = {1'b0, aose_pkg::abs_diff(cur1_q, tn1_q)}
               + {1'b0, aose_pkg::abs_diff(cur2_q, tn2_q)};
  assign delta_w = $signed({1'b0, new_e}) - $signed({1'b0, old_e});

  assign accept = (delta_q <= 0) ||
                  ($signed({delta_q[DB-1], delta_q}) < $signed({1'b0, thr_q}));

  assign energy_we = (cmd_i.op == aose_pkg::OP_LOAD) ||
                     ((cmd_i.op == aose_pkg::OP_P_DEC) && accept);
  assign add_v = (cmd_i.op == aose_pkg::OP_LOAD) ?
                 $signed({{(DB+1-PB){1'b0}}, aose_pkg::abs_diff(cv_q, tv_q)}) :
                 $signed({delta_q[DB-1], delta_q});
  assign esum = $signed({2'b00, energy_q}) + $signed({{(EB+1-DB){add_v[DB]}}, add_v});

  assign stat_o.clear_last = &clr_q;
  assign stat_o.ok1        = ok1;
  assign stat_o.ok2        = ok2;
  assign stat_o.accept     = accept;
  assign stat_o.slot_free  = !ov_q || out_o.ready;
  assign in_i.ready        = (cmd_i.op == aose_pkg::OP_IDLE);

  // address and write selection per step
  always_comb begin
    cur_ra = src_rd;
    tgt_ra = q_q;
    off_ra = src_rd;
    src_ra = p_q;
    img_we = 1'b0;
    img_wa = p_q;
    off_we = 1'b0;
    off_wa = s1_q;
    off_wd = n1_q;
    src_we = 1'b0;
    src_wa = p_q;
    src_wd = s2_q;
    case (cmd_i.op)
      aose_pkg::OP_CLEAR: begin
        off_we = 1'b1;
        off_wa = clr_q;
        off_wd = '0;
        src_we = 1'b1;
        src_wa = clr_q;
        src_wd = clr_q;
      end
      aose_pkg::OP_LOAD:   img_we = 1'b1;
      aose_pkg::OP_P_CHK1: begin
        src_ra = q_cell;
        tgt_ra = q_cell;
      end
      aose_pkg::OP_P_OFF2: tgt_ra = {aose_pkg::wrap_coord(s1_q[LB-1:CB], o1_q[2*OB-1:OB]),
                                     aose_pkg::wrap_coord(s1_q[CB-1:0], o1_q[OB-1:0])};
      aose_pkg::OP_P_CHK2: tgt_ra = {aose_pkg::wrap_coord(s2_q[LB-1:CB], off_rd[2*OB-1:OB]),
                                     aose_pkg::wrap_coord(s2_q[CB-1:0], off_rd[OB-1:0])};
      aose_pkg::OP_P_RD3:  tgt_ra = {aose_pkg::wrap_coord(s2_q[LB-1:CB], n2_q[2*OB-1:OB]),
                                     aose_pkg::wrap_coord(s2_q[CB-1:0], n2_q[OB-1:0])};
      aose_pkg::OP_P_DEC: begin
        off_we = accept;
        src_we = accept;
      end
      aose_pkg::OP_P_WB2: begin
        off_we = 1'b1;
        off_wa = s2_q;
        off_wd = n2_q;
        src_we = 1'b1;
        src_wa = q_q;
        src_wd = s1_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (img_we) begin
      cur_mem[img_wa] <= cv_q;
      tgt_mem[img_wa] <= tv_q;
    end
    cur_rd <= cur_mem[cur_ra];
    tgt_rd <= tgt_mem[tgt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (off_we) off_mem[off_wa] <= off_wd;
    off_rd <= off_mem[off_ra];
  end

  always_ff @(posedge clk_i) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    src_rd <= src_mem[src_ra];
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      p_q   <= {in_i.pos_y, in_i.pos_x};
      stx_q <= in_i.step_x;
      sty_q <= in_i.step_y;
      cv_q  <= in_i.current_value;
      tv_q  <= in_i.target_value;
      thr_q <= in_i.accept_threshold;
      res_delta_q <= '0;
      res_off_q   <= '0;
      res_src_q   <= '0;
    end
    case (cmd_i.op)
      aose_pkg::OP_LOAD:  res_status_q <= aose_pkg::ST_LOADED;
      aose_pkg::OP_R_OFF: s1_q <= src_rd;
      aose_pkg::OP_R_FIN: begin
        res_src_q    <= s1_q;
        res_off_q    <= off_rd;
        res_status_q <= aose_pkg::ST_READOUT;
      end
      aose_pkg::OP_P_OFF1: s1_q <= src_rd;
      aose_pkg::OP_P_CHK1: begin
        o1_q   <= off_rd;
        cur1_q <= cur_rd;
        n1_q   <= {n1y[OB-1:0], n1x[OB-1:0]};
        q_q    <= q_cell;
        if (!ok1) res_status_q <= aose_pkg::ST_NOT_APPLICABLE;
      end
      aose_pkg::OP_P_OFF2: begin
        s2_q  <= src_rd;
        tn1_q <= tgt_rd;
      end
      aose_pkg::OP_P_CHK2: begin
        cur2_q <= cur_rd;
        to1_q  <= tgt_rd;
        n2_q   <= {n2y[OB-1:0], n2x[OB-1:0]};
        if (!ok2) res_status_q <= aose_pkg::ST_NOT_APPLICABLE;
      end
      aose_pkg::OP_P_RD3:  to2_q <= tgt_rd;
      aose_pkg::OP_P_RD4:  tn2_q <= tgt_rd;
      aose_pkg::OP_P_EVAL: delta_q <= delta_w[DB-1:0];
      aose_pkg::OP_P_DEC: begin
        res_delta_q  <= delta_q;
        res_status_q <= accept ? aose_pkg::ST_ACCEPTED : aose_pkg::ST_DECLINED;
      end
      default: ;
    endcase
  end

  // control-side registers: sweep counter, energy, count, output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q    <= '0;
      energy_q <= '0;
      count_q  <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (cmd_i.op == aose_pkg::OP_CLEAR) clr_q <= clr_q + 1'b1;
      if (energy_we) begin
        if (esum < 0) energy_q <= '0;
        else if (esum > $signed({2'b00, EnergyMax})) energy_q <= EnergyMax;
        else energy_q <= esum[EB-1:0];
      end
      if ((cmd_i.op == aose_pkg::OP_P_DEC) && accept && (count_q != CountMax)) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.push) ov_q <= 1'b1;
      else if (out_o.ready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_o.status         <= res_status_q;
      out_o.energy_delta   <= res_delta_q;
      out_o.total_energy   <= energy_q;
      out_o.accepted_count <= count_q;
      out_o.read_offset_x  <= res_off_q[OB-1:0];
      out_o.read_offset_y  <= res_off_q[2*OB-1:OB];
      out_o.read_source_x  <= res_src_q[CB-1:0];
      out_o.read_source_y  <= res_src_q[LB-1:CB];
    end
  end

  assign out_o.valid = ov_q;

endmodule

@@ rtl/annealing_offset_swap_engine_core.sv @@
// Top level of the annealing offset swap engine.
// Usage:
//   in_i carries one request per valid/ready handshake. mode selects a pixel
//   load (current and target image written, absolute difference added to the
//   energy), a swap proposal (offset bound check, energy change, Metropolis
//   accept against accept_threshold) or a readout of one map entry.
//   out_o returns exactly one result per load, proposal or readout; mode 3
//   is dropped without a result.
// Latency and throughput (cycles from accept to result valid):
//   load 2, readout 4, proposal 4 when the first bound fails, 6 when the
//   partner bound fails, 10 when declined, 11 when accepted. The block works on
//   one request at a time; the chain of dependent reads through the source,
//   offset and image memories (one read port each) sets that figure.
// Reset:
//   after rst_ni is released a sweep of 4096 cycles writes the offset map to
//   zero and the source map to the identity; in_i.ready stays low until done.
// Stall:
//   a finished result sits in the output register; when the receiver holds
//   ready low the next result waits in the done step and no new request is
//   taken until the register frees.
module annealing_offset_swap_engine_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  aose_in_if.sink    in_i,
  aose_out_if.source out_o
);

  aose_pkg::cmd_t  cmd;
  aose_pkg::stat_t stat;
  logic            ctrl_ready;

  // sequencer: steps through the memory accesses of each request
  aose_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_mode_i  (in_i.mode),
    .in_ready_o (ctrl_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memories, arithmetic and output register; drives in_i.ready from the op
  aose_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  a_ready_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_ready == in_i.ready)
    else $error("request ready differs between sequencer and datapath");

endmodule

@@ sim/tb.sv @@
// Self-checking testbench of the annealing offset swap engine core.
`timescale 1ns / 100ps

module tb;

  localparam int IdleLimit = 20000;   // covers the map sweep over all 4096 cells after reset
  localparam int RandItems = 1800;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [1:0]        mode;
    logic [5:0]        px;
    logic [5:0]        py;
    logic signed [3:0] stx;
    logic signed [3:0] sty;
    logic [7:0]        cur;
    logic [7:0]        tgt;
    logic [9:0]        thr;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [9:0]  delta;
    logic [19:0]        energy;
    logic [23:0]        count;
    logic signed [3:0]  rox;
    logic signed [3:0]  roy;
    logic [5:0]         rsx;
    logic [5:0]         rsy;
  } res_t;

  typedef struct {
    req_t req;
    bit   typed;
    res_t res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  aose_in_if  req_if ();
  aose_out_if res_if ();

  annealing_offset_swap_engine_core DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_if),
    .out_o (res_if)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Shadow copy of the engine state.
  logic [7:0] pix_cur    [aose_pkg::CellCount];
  logic [7:0] pix_tgt    [aose_pkg::CellCount];
  bit         pix_loaded [aose_pkg::CellCount];
  int         map_off_x  [aose_pkg::CellCount];
  int         map_off_y  [aose_pkg::CellCount];
  int         map_src_x  [aose_pkg::CellCount];
  int         map_src_y  [aose_pkg::CellCount];
  int         run_energy;
  int         swap_total;

  res_t       expected_q [$];
  dir_row_t   dir_rows   [$];
  int         errors;
  int         results_seen;

  function automatic int cell_of(int x, int y);
    return ((y & 63) << 6) | (x & 63);
  endfunction

  function automatic bit off_ok(int v);
    return v >= -int'(aose_pkg::MaxOffset) && v <= int'(aose_pkg::MaxOffset);
  endfunction

  function automatic int pix_cost(int sx, int sy, int ox, int oy);
    int c, t;
    c = int'(pix_cur[cell_of(sx, sy)]);
    t = int'(pix_tgt[cell_of(sx + ox, sy + oy)]);
    return (c > t) ? c - t : t - c;
  endfunction

  function automatic void add_energy(int d);
    run_energy += d;
    if (run_energy < 0) run_energy = 0;
    if (run_energy > 1048575) run_energy = 1048575;
  endfunction

  // True when a proposal would evaluate costs on a pixel never loaded.
  function automatic bit touches_unloaded(req_t r);
    int p, s1x, s1y, o1x, o1y, n1x, n1y, q, s2x, s2y, o2x, o2y, n2x, n2y;
    p   = cell_of(int'(r.px), int'(r.py));
    s1x = map_src_x[p];
    s1y = map_src_y[p];
    o1x = map_off_x[cell_of(s1x, s1y)];
    o1y = map_off_y[cell_of(s1x, s1y)];
    n1x = o1x + int'(r.stx);
    n1y = o1y + int'(r.sty);
    if (!off_ok(n1x) || !off_ok(n1y)) return 1'b0;
    q   = cell_of(s1x + n1x, s1y + n1y);
    s2x = map_src_x[q];
    s2y = map_src_y[q];
    o2x = map_off_x[cell_of(s2x, s2y)];
    o2y = map_off_y[cell_of(s2x, s2y)];
    n2x = o2x - int'(r.stx);
    n2y = o2y - int'(r.sty);
    if (!off_ok(n2x) || !off_ok(n2y)) return 1'b0;
    return !(pix_loaded[cell_of(s1x, s1y)] && pix_loaded[cell_of(s1x + o1x, s1y + o1y)] &&
             pix_loaded[cell_of(s1x + n1x, s1y + n1y)] && pix_loaded[cell_of(s2x, s2y)] &&
             pix_loaded[cell_of(s2x + o2x, s2y + o2y)] &&
             pix_loaded[cell_of(s2x + n2x, s2y + n2y)]);
  endfunction

  // Applies one request to the shadow state; returns 0 when no result follows.
  function automatic bit apply_swap_step(req_t r, output res_t o);
    int p, s1x, s1y, o1x, o1y, n1x, n1y, q, s2x, s2y, o2x, o2y, n2x, n2y;
    int d, a, b;
    o = '0;
    p = cell_of(int'(r.px), int'(r.py));
    case (aose_pkg::mode_e'(r.mode))
      aose_pkg::MODE_NONE: return 1'b0;
      aose_pkg::MODE_LOAD: begin
        pix_cur[p]    = r.cur;
        pix_tgt[p]    = r.tgt;
        pix_loaded[p] = 1'b1;
        a = int'(r.cur);
        b = int'(r.tgt);
        add_energy((a > b) ? a - b : b - a);
        o.status = aose_pkg::ST_LOADED;
      end
      aose_pkg::MODE_READ: begin
        o.rsx    = 6'(map_src_x[p]);
        o.rsy    = 6'(map_src_y[p]);
        o.rox    = 4'(map_off_x[cell_of(map_src_x[p], map_src_y[p])]);
        o.roy    = 4'(map_off_y[cell_of(map_src_x[p], map_src_y[p])]);
        o.status = aose_pkg::ST_READOUT;
      end
      default: begin
        s1x = map_src_x[p];
        s1y = map_src_y[p];
        o1x = map_off_x[cell_of(s1x, s1y)];
        o1y = map_off_y[cell_of(s1x, s1y)];
        n1x = o1x + int'(r.stx);
        n1y = o1y + int'(r.sty);
        o.status = aose_pkg::ST_NOT_APPLICABLE;
        if (off_ok(n1x) && off_ok(n1y)) begin
          q   = cell_of(s1x + n1x, s1y + n1y);
          s2x = map_src_x[q];
          s2y = map_src_y[q];
          o2x = map_off_x[cell_of(s2x, s2y)];
          o2y = map_off_y[cell_of(s2x, s2y)];
          n2x = o2x - int'(r.stx);
          n2y = o2y - int'(r.sty);
          if (off_ok(n2x) && off_ok(n2y)) begin
            d = pix_cost(s1x, s1y, n1x, n1y) + pix_cost(s2x, s2y, n2x, n2y)
              - pix_cost(s1x, s1y, o1x, o1y) - pix_cost(s2x, s2y, o2x, o2y);
            o.delta = 10'(d);
            if (d <= 0 || d < int'(r.thr)) begin
              // Zero step: partner is the same source, so these writes are no-ops.
              map_off_x[cell_of(s1x, s1y)] = n1x;
              map_off_y[cell_of(s1x, s1y)] = n1y;
              map_off_x[cell_of(s2x, s2y)] = n2x;
              map_off_y[cell_of(s2x, s2y)] = n2y;
              map_src_x[p] = s2x;
              map_src_y[p] = s2y;
              map_src_x[q] = s1x;
              map_src_y[q] = s1y;
              add_energy(d);
              if (swap_total < 16777215) swap_total++;
              o.status = aose_pkg::ST_ACCEPTED;
            end else begin
              o.status = aose_pkg::ST_DECLINED;
            end
          end
        end
      end
    endcase
    o.energy = 20'(run_energy);
    o.count  = 24'(swap_total);
    return 1'b1;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("result %0d: %s got %0d expected %0d", results_seen, field, got, want);
    errors++;
  endtask

  function automatic req_t mk_req(aose_pkg::mode_e m, int x, int y, int sx, int sy,
                                  int c, int t, int th);
    req_t r;
    r.mode = m;      r.px  = 6'(x);  r.py  = 6'(y);  r.stx = 4'(sx); r.sty = 4'(sy);
    r.cur  = 8'(c);  r.tgt = 8'(t);  r.thr = 10'(th);
    return r;
  endfunction

  function automatic void add_row(req_t r, bit typed, res_t res);
    dir_row_t row;
    row.req = r;  row.typed = typed;  row.res = res;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic res_t mk_res(aose_pkg::status_e s, int d, int e, int c,
                                  int ox, int oy, int sx, int sy);
    res_t o;
    o.status = s;       o.delta = 10'(d);  o.energy = 20'(e);  o.count = 24'(c);
    o.rox    = 4'(ox);  o.roy   = 4'(oy);  o.rsx    = 6'(sx);  o.rsy   = 6'(sy);
    return o;
  endfunction

  // Window of 16x16 pixels straddling the wrap edge; proposals live here.
  function automatic int win_coord();
    return (int'($urandom_range(0, 15)) + 56) & 63;
  endfunction

  function automatic int rand_step();
    return ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 12)) - 6;
  endfunction

  function automatic int rand_thr();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 1023;
      2:       return int'($urandom_range(0, 64));
      default: return int'($urandom_range(0, 1023));
    endcase
  endfunction

  function automatic int rand_pix();
    return int'($urandom_range(0, 255));
  endfunction

  function automatic req_t rand_request(int n);
    req_t r;
    int   pick, tries;
    pick = int'($urandom_range(0, 99));
    // Early phase fills the window so that proposals can be evaluated.
    if (n < 300) pick = (pick < 85) ? 0 : pick;
    if (pick < 25) begin
      return mk_req(aose_pkg::MODE_LOAD, win_coord(), win_coord(), rand_step(), rand_step(),
                    rand_pix(), rand_pix(), rand_thr());
    end else if (pick < 80) begin
      for (tries = 0; tries < 20; tries++) begin
        r = mk_req(aose_pkg::MODE_PROPOSE, win_coord(), win_coord(), rand_step(),
                   rand_step(), rand_pix(), rand_pix(), rand_thr());
        if (!touches_unloaded(r)) return r;
      end
    end else if (pick < 96) begin
      ;
    end else if (pick < 98) begin
      return mk_req(aose_pkg::MODE_NONE, int'($urandom_range(0, 63)),
                    int'($urandom_range(0, 63)), rand_step(), rand_step(), rand_pix(),
                    rand_pix(), rand_thr());
    end else begin
      return mk_req(aose_pkg::MODE_LOAD, int'($urandom_range(0, 63)),
                    int'($urandom_range(0, 63)), rand_step(), rand_step(), rand_pix(),
                    rand_pix(), rand_thr());
    end
    return mk_req(aose_pkg::MODE_READ, int'($urandom_range(0, 63)),
                  int'($urandom_range(0, 63)), rand_step(), rand_step(), rand_pix(),
                  rand_pix(), rand_thr());
  endfunction

  // Gap before the next request or result; some stretches run back to back.
  function automatic int draw_gap(int n);
    return ((n / 150) % 4 == 1) ? 0 : int'($urandom_range(0, 10));
  endfunction

  // Drive one request whose expectation is already queued; wait for the handshake.
  task automatic drive_request(req_t r, int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid            <= 1'b1;
    req_if.mode             <= r.mode;
    req_if.pos_x            <= r.px;
    req_if.pos_y            <= r.py;
    req_if.step_x           <= r.stx;
    req_if.step_y           <= r.sty;
    req_if.current_value    <= r.cur;
    req_if.target_value     <= r.tgt;
    req_if.accept_threshold <= r.thr;
    do @(posedge clk); while (!req_if.ready);
  endtask

  initial begin
    int   i;
    res_t want, none;
    req_t r;
    errors       = 0;
    results_seen = 0;
    run_energy   = 0;
    swap_total   = 0;
    for (i = 0; i < aose_pkg::CellCount; i++) begin
      pix_cur[i] = '0; pix_tgt[i] = '0; pix_loaded[i] = 1'b0;
      map_off_x[i] = 0; map_off_y[i] = 0;
      map_src_x[i] = i & 63; map_src_y[i] = i >> 6;
    end
    rst_n                   <= 1'b0;
    req_if.valid            <= 1'b0;
    req_if.mode             <= aose_pkg::MODE_NONE;
    req_if.pos_x            <= '0;
    req_if.pos_y            <= '0;
    req_if.step_x           <= '0;
    req_if.step_y           <= '0;
    req_if.current_value    <= '0;
    req_if.target_value     <= '0;
    req_if.accept_threshold <= '0;
    none = '0;

    // Directed rows: reset map, pixel extremes, zero step, threshold boundary.
    add_row(mk_req(aose_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(aose_pkg::ST_READOUT, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk_req(aose_pkg::MODE_READ, 63, 63, 0, 0, 0, 0, 0), 1,
            mk_res(aose_pkg::ST_READOUT, 0, 0, 0, 0, 0, 63, 63));
    add_row(mk_req(aose_pkg::MODE_LOAD, 0, 0, 0, 0, 255, 0, 0), 1,
            mk_res(aose_pkg::ST_LOADED, 0, 255, 0, 0, 0, 0, 0));
    add_row(mk_req(aose_pkg::MODE_LOAD, 63, 63, -6, 6, 0, 255, 1023), 1,
            mk_res(aose_pkg::ST_LOADED, 0, 510, 0, 0, 0, 0, 0));
    // Repeated load adds again, nothing is taken back.
    add_row(mk_req(aose_pkg::MODE_LOAD, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(aose_pkg::ST_LOADED, 0, 510, 0, 0, 0, 0, 0));
    add_row(mk_req(aose_pkg::MODE_LOAD, 63, 0, 0, 0, 17, 200, 0), 1,
            mk_res(aose_pkg::ST_LOADED, 0, 693, 0, 0, 0, 0, 0));
    add_row(mk_req(aose_pkg::MODE_LOAD, 1, 0, 0, 0, 90, 40, 0), 1,
            mk_res(aose_pkg::ST_LOADED, 0, 743, 0, 0, 0, 0, 0));
    add_row(mk_req(aose_pkg::MODE_NONE, 5, 5, 1, 1, 1, 1, 1), 0, none);
    add_row(mk_req(aose_pkg::MODE_PROPOSE, 0, 0, 0, 0, 0, 0, 0), 1,
            mk_res(aose_pkg::ST_ACCEPTED, 0, 743, 1, 0, 0, 0, 0));
    // Swap across the wrap edge, then bound violation on the moved source.
    add_row(mk_req(aose_pkg::MODE_PROPOSE, 0, 0, -1, 0, 0, 0, 1023), 0, none);
    add_row(mk_req(aose_pkg::MODE_PROPOSE, 63, 0, -6, 0, 0, 0, 0), 0, none);
    add_row(mk_req(aose_pkg::MODE_READ, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(aose_pkg::MODE_READ, 63, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(aose_pkg::MODE_PROPOSE, 0, 0, -1, 0, 0, 0, 0), 0, none);
    // Uphill change of 34: declined at 0 and at 34, accepted at 35.
    add_row(mk_req(aose_pkg::MODE_PROPOSE, 0, 0, -1, 0, 0, 0, 0), 0, none);
    add_row(mk_req(aose_pkg::MODE_PROPOSE, 0, 0, -1, 0, 0, 0, 34), 0, none);
    add_row(mk_req(aose_pkg::MODE_PROPOSE, 0, 0, -1, 0, 0, 0, 35), 0, none);
    add_row(mk_req(aose_pkg::MODE_PROPOSE, 1, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(aose_pkg::MODE_READ, 63, 0, 0, 0, 0, 0, 0), 0, none);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      r = dir_rows[k].req;
      if (dir_rows[k].typed) begin
        // Typed rows still update the shadow state; the typed value is what gets checked.
        void'(apply_swap_step(r, want));
        expected_q = {expected_q, dir_rows[k].res};
      end else if (apply_swap_step(r, want)) begin
        expected_q = {expected_q, want};
      end
      drive_request(r, int'($urandom_range(0, 10)));
    end
    for (i = 0; i < RandItems; i++) begin
      r = rand_request(i);
      if (apply_swap_step(r, want)) expected_q = {expected_q, want};
      drive_request(r, draw_gap(i));
    end
    req_if.valid <= 1'b0;

    while (expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off so the engine backs up.
  initial begin
    int   gap;
    res_t got, want;
    res_if.ready <= 1'b0;
    forever begin
      gap = draw_gap(results_seen);
      if (results_seen == 500) gap = HoldCycles;
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      got.status = res_if.status;
      got.delta  = res_if.energy_delta;
      got.energy = res_if.total_energy;
      got.count  = res_if.accepted_count;
      got.rox    = res_if.read_offset_x;
      got.roy    = res_if.read_offset_y;
      got.rsx    = res_if.read_source_x;
      got.rsy    = res_if.read_source_y;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, status", int'(got.status), -1);
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.delta  !== want.delta)
          report_mismatch("energy_delta", int'(got.delta), int'(want.delta));
        if (got.energy !== want.energy)
          report_mismatch("total_energy", int'(got.energy), int'(want.energy));
        if (got.count  !== want.count)
          report_mismatch("accepted_count", int'(got.count), int'(want.count));
        if (got.rox    !== want.rox)
          report_mismatch("read_offset_x", int'(got.rox), int'(want.rox));
        if (got.roy    !== want.roy)
          report_mismatch("read_offset_y", int'(got.roy), int'(want.roy));
        if (got.rsx    !== want.rsx)
          report_mismatch("read_source_x", int'(got.rsx), int'(want.rsx));
        if (got.rsy    !== want.rsy)
          report_mismatch("read_source_y", int'(got.rsy), int'(want.rsy));
      end
      results_seen++;
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
